/* design/assert_macros.svh */
// Assertion macros shared by the mailbox RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every rising clock edge outside reset.
`define FMWQ_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Same-cycle implication.
`define FMWQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FMWQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/fmwq_pkg.sv */
// Shared types, codes and defaults for the mailbox with waiter queue.
// No dependencies; used by fmwq_if, fmwq_core and the top level.
package fmwq_pkg;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int RID_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;

  // Parameter defaults
  localparam int ITEM_DEPTH_DEF   = 16;
  localparam int WAITER_DEPTH_DEF = 16;
  localparam int ITEM_WIDTH_DEF   = 32;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BGET  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TRY   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_COUNT = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PARKED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRYFAIL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_COUNT     = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  item_value;
    logic [RID_W-1:0]    requester_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  delivered_item;
    logic [RID_W-1:0]    served_requester;
    logic [COUNT_W-1:0]  taken_total;
  } rsp_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic               item_empty;
    logic               waiter_empty;
    logic [COUNT_W-1:0] taken;
  } core_stat_t;

endpackage

/* design/fmwq_if.sv */
// Valid/ready channel interfaces for operation requests and results.
// Depends on fmwq_pkg for the payload types.
interface fmwq_req_if;
  logic           valid;
  logic           ready;
  fmwq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fmwq_rsp_if;
  logic           valid;
  logic           ready;
  fmwq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/fmwq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fmwq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/fmwq_core.sv */
// Item and waiter queues: pointers, levels, taken counter, the two RAMs
// and the decision for one operation. Depends on fmwq_pkg and fmwq_ram.
module fmwq_core #(
  parameter int ITEM_DEPTH   = fmwq_pkg::ITEM_DEPTH_DEF,
  parameter int WAITER_DEPTH = fmwq_pkg::WAITER_DEPTH_DEF,
  parameter int ITEM_WIDTH   = fmwq_pkg::ITEM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  fmwq_pkg::req_t       req,
  output fmwq_pkg::rsp_t       result,
  output fmwq_pkg::core_stat_t stat
);

  localparam int IA_W   = $clog2(ITEM_DEPTH);
  localparam int IL_W   = $clog2(ITEM_DEPTH + 1);
  localparam int WA_W   = $clog2(WAITER_DEPTH);
  localparam int WL_W   = $clog2(WAITER_DEPTH + 1);
  localparam int KEEP_W = (ITEM_WIDTH < fmwq_pkg::VALUE_W) ? ITEM_WIDTH : fmwq_pkg::VALUE_W;

  // Where the handed-out item or served id comes from
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_ITEM = 2'd1;
  localparam logic [1:0] SRC_WAIT = 2'd2;

  logic [IA_W-1:0] item_head, item_tail;
  logic [IL_W-1:0] item_level;
  logic [WA_W-1:0] waiter_head, waiter_tail;
  logic [WL_W-1:0] waiter_level;
  logic [fmwq_pkg::COUNT_W-1:0] taken;

  logic [ITEM_WIDTH-1:0]     put_word;
  logic [ITEM_WIDTH-1:0]     item_rdata;
  logic [fmwq_pkg::RID_W-1:0] waiter_rdata;

  logic item_has, item_full, waiter_has, waiter_full;
  logic push_item, pop_item, push_wait, pop_wait;
  logic [fmwq_pkg::STATUS_W-1:0] status_d;
  logic [1:0]                    src_d;
  logic [fmwq_pkg::RID_W-1:0]    served_d;

  // Pending result, captured at accept
  logic [fmwq_pkg::STATUS_W-1:0] pend_status;
  logic [1:0]                    pend_src;
  logic [ITEM_WIDTH-1:0]         pend_word;
  logic [fmwq_pkg::RID_W-1:0]    pend_served;

  assign item_has    = item_level != '0;
  assign item_full   = item_level == IL_W'(ITEM_DEPTH);
  assign waiter_has  = waiter_level != '0;
  assign waiter_full = waiter_level == WL_W'(WAITER_DEPTH);

  // Item value cut to the stored width
  always_comb begin
    put_word = '0;
    put_word[KEEP_W-1:0] = req.item_value[KEEP_W-1:0];
  end

  // Operation decode
  always_comb begin
    push_item = 1'b0;
    pop_item  = 1'b0;
    push_wait = 1'b0;
    pop_wait  = 1'b0;
    status_d  = fmwq_pkg::ST_COUNT;
    src_d     = SRC_NONE;
    served_d  = '0;
    unique case (req.opcode)
      fmwq_pkg::OP_PUT: begin
        if (waiter_has) begin
          pop_wait = 1'b1;
          status_d = fmwq_pkg::ST_DELIVERED;
          src_d    = SRC_WAIT;
        end else if (!item_full) begin
          push_item = 1'b1;
          status_d  = fmwq_pkg::ST_STORED;
        end else begin
          status_d = fmwq_pkg::ST_FULL;
        end
      end
      fmwq_pkg::OP_BGET: begin
        if (item_has) begin
          pop_item = 1'b1;
          status_d = fmwq_pkg::ST_DELIVERED;
          src_d    = SRC_ITEM;
          served_d = req.requester_id;
        end else if (!waiter_full) begin
          push_wait = 1'b1;
          status_d  = fmwq_pkg::ST_PARKED;
          served_d  = req.requester_id;
        end else begin
          status_d = fmwq_pkg::ST_FULL;
        end
      end
      fmwq_pkg::OP_TRY: begin
        if (item_has) begin
          pop_item = 1'b1;
          status_d = fmwq_pkg::ST_DELIVERED;
          src_d    = SRC_ITEM;
          served_d = req.requester_id;
        end else begin
          status_d = fmwq_pkg::ST_TRYFAIL;
        end
      end
      fmwq_pkg::OP_COUNT: begin
        status_d = fmwq_pkg::ST_COUNT;
      end
    endcase
  end

  // Pointers, levels and taken counter
  always_ff @(posedge clk) begin
    if (rst) begin
      item_head    <= '0;
      item_tail    <= '0;
      item_level   <= '0;
      waiter_head  <= '0;
      waiter_tail  <= '0;
      waiter_level <= '0;
      taken        <= '0;
    end else if (accept) begin
      if (push_item) begin
        item_tail  <= (item_tail == IA_W'(ITEM_DEPTH - 1)) ? '0 : item_tail + IA_W'(1);
        item_level <= item_level + IL_W'(1);
      end
      if (pop_item) begin
        item_head  <= (item_head == IA_W'(ITEM_DEPTH - 1)) ? '0 : item_head + IA_W'(1);
        item_level <= item_level - IL_W'(1);
      end
      if (push_wait) begin
        waiter_tail  <= (waiter_tail == WA_W'(WAITER_DEPTH - 1)) ? '0
                                                                 : waiter_tail + WA_W'(1);
        waiter_level <= waiter_level + WL_W'(1);
      end
      if (pop_wait) begin
        waiter_head  <= (waiter_head == WA_W'(WAITER_DEPTH - 1)) ? '0
                                                                 : waiter_head + WA_W'(1);
        waiter_level <= waiter_level - WL_W'(1);
      end
      if (status_d == fmwq_pkg::ST_DELIVERED) begin
        taken <= taken + fmwq_pkg::COUNT_W'(1);
      end
    end
  end

  // Capture the decision; the RAM read at head lands in the cycle after accept
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_d;
      pend_src    <= src_d;
      pend_word   <= put_word;
      pend_served <= served_d;
    end
  end

  fmwq_ram #(
    .WIDTH(ITEM_WIDTH),
    .DEPTH(ITEM_DEPTH)
  ) u_item_ram (
    .clk  (clk),
    .we   (accept && push_item),
    .waddr(item_tail),
    .wdata(put_word),
    .raddr(item_head),
    .rdata(item_rdata)
  );

  fmwq_ram #(
    .WIDTH(fmwq_pkg::RID_W),
    .DEPTH(WAITER_DEPTH)
  ) u_waiter_ram (
    .clk  (clk),
    .we   (accept && push_wait),
    .waddr(waiter_tail),
    .wdata(req.requester_id),
    .raddr(waiter_head),
    .rdata(waiter_rdata)
  );

  // Result assembly from the pending decision and RAM read data
  always_comb begin
    logic [ITEM_WIDTH-1:0] word;
    word = (pend_src == SRC_ITEM) ? item_rdata : pend_word;
    result.status = pend_status;
    result.delivered_item = '0;
    if (pend_status == fmwq_pkg::ST_DELIVERED) begin
      result.delivered_item[KEEP_W-1:0] = word[KEEP_W-1:0];
    end
    result.served_requester = (pend_src == SRC_WAIT) ? waiter_rdata : pend_served;
    result.taken_total = taken;
  end

  assign stat.item_empty   = !item_has;
  assign stat.waiter_empty = !waiter_has;
  assign stat.taken        = taken;

endmodule

/* design/fifo_mailbox_with_waiter_queue.sv */
// Mailbox FIFO with a parked-waiter queue. After accept the sequencer enters S_EXEC
// for the registered RAM read; the result then goes to the output register and stays
// valid until taken. No new item is accepted until the sequencer is back in S_IDLE.
// The next item is taken in the cycle its predecessor's result is taken.
// Reset (rst, synchronous) empties both queues and clears the taken count;
// RAM contents are not cleared, so no clearing pass is needed.
`include "assert_macros.svh"
module fifo_mailbox_with_waiter_queue #(
  parameter int ITEM_DEPTH   = fmwq_pkg::ITEM_DEPTH_DEF,
  parameter int WAITER_DEPTH = fmwq_pkg::WAITER_DEPTH_DEF,
  parameter int ITEM_WIDTH   = fmwq_pkg::ITEM_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  fmwq_req_if.sink   req,
  fmwq_rsp_if.source rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state;
  logic                 accept;
  logic                 out_valid;
  fmwq_pkg::rsp_t       out_data;
  fmwq_pkg::rsp_t       result;
  fmwq_pkg::core_stat_t stat;
  logic                 in_exec;
  logic                 is_deliv;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  fmwq_core #(
    .ITEM_DEPTH  (ITEM_DEPTH),
    .WAITER_DEPTH(WAITER_DEPTH),
    .ITEM_WIDTH  (ITEM_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .req   (req.data),
    .result(result),
    .stat  (stat)
  );

  // Sequencer: accept, then S_EXEC for the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EXEC) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      out_data <= result;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Checks
  assign in_exec  = state == S_EXEC;
  assign is_deliv = result.status == fmwq_pkg::ST_DELIVERED;

  `FMWQ_ASSERT(a_no_items_and_waiters, clk, rst, stat.item_empty || stat.waiter_empty)
  `FMWQ_ASSERT_IMP(a_count_on_delivery, clk, rst, in_exec, is_deliv != $stable(stat.taken))
  `FMWQ_ASSERT_NXT(a_exec_fills_output, clk, rst, in_exec, rsp.valid && state == S_IDLE)

endmodule
